[hw/rtl/ahrd_pkg.sv]
// ----------------------------------------------------------------------------
// ahrd_pkg
// Shared types, codes and helpers for the ASCII hex response deframer.
// ----------------------------------------------------------------------------
package ahrd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [NIB_W-1:0]   t_nibble;
    typedef logic [STAT_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_DATA = 3'd1,
        PH_ETX  = 3'd2,
        PH_CKHI = 3'd3,
        PH_CKLO = 3'd4
    } t_phase;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_MISMATCH = 2'd1;
    localparam t_status ST_NAK      = 2'd2;
    localparam t_status ST_BADCHAR  = 2'd3;

    localparam t_cfg_idx CFG_PAYLOAD_BYTES = 2'd0;
    localparam t_cfg_idx CFG_START_CODE    = 2'd1;
    localparam t_cfg_idx CFG_NAK_CODE      = 2'd2;

    localparam t_byte RST_PAYLOAD_BYTES = 8'd1;
    localparam t_byte RST_START_CODE    = 8'd2;
    localparam t_byte RST_NAK_CODE      = 8'd21;

    localparam t_byte CHAR_0 = 8'h30;
    localparam t_byte CHAR_9 = 8'h39;
    localparam t_byte CHAR_A = 8'h41;
    localparam t_byte CHAR_F = 8'h46;
    localparam t_byte HEX_A_OFFSET = CHAR_A - 8'd10;

    typedef struct packed {
        logic    bad;
        t_nibble value;
    } t_hex;

    function automatic t_hex hex_decode(input t_byte c);
        t_hex   h;
        t_byte  d;
        h.bad   = 1'b1;
        h.value = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            d       = c - CHAR_0;
            h.bad   = 1'b0;
            h.value = d[NIB_W-1:0];
        end else if (c >= CHAR_A && c <= CHAR_F) begin
            d       = c - HEX_A_OFFSET;
            h.bad   = 1'b0;
            h.value = d[NIB_W-1:0];
        end
        return h;
    endfunction

endpackage

[hw/rtl/ascii_hex_response_deframer.sv]
// ----------------------------------------------------------------------------
// ascii_hex_response_deframer
// Splits received characters into decoded data bytes and frame status.
//
// Received characters enter on the rx channel (valid/ready), one per
// transaction. Results leave on the res channel (valid/ready): a decoded data
// byte (result_kind 0) or a status (result_kind 1) with last set on the
// status that closes a frame. Most characters produce no result.
// The configuration port is a plain write port with no wait states; index 0
// is the payload byte count, 1 the start code and 2 the NAK code. Writes are
// to be made by the user while the block is idle; the block does not enforce it.
// A character is taken into an input register, decoded by one level of
// logic and any result is then loaded into the output register.
// One character is taken in every cycle as long as the output register
// is free or being emptied.
// When the receiver stalls, a waiting result holds the output register and
// the input register, and rx ready falls once both are full.
// Reset restores the register defaults and returns the block to hunting for
// a start code, with both registers empty.
// ----------------------------------------------------------------------------
module ascii_hex_response_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  ahrd_pkg::t_cfg_idx i_cfg_index,
    input  ahrd_pkg::t_byte  i_cfg_data,
    input  logic             i_rx_valid,
    output logic             o_rx_ready,
    input  ahrd_pkg::t_byte  i_rx_byte,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic             o_result_kind,
    output ahrd_pkg::t_byte  o_data_byte,
    output ahrd_pkg::t_status o_status,
    output logic             o_last
);
    import ahrd_pkg::*;

    t_byte   r_payload_bytes;
    t_byte   r_start_code;
    t_byte   r_nak_code;

    logic    r_in_valid;
    t_byte   r_in_byte;

    t_phase  r_phase,  n_phase;
    t_count  r_count,  n_count;
    t_byte   r_sum,    n_sum;
    t_nibble r_high,   n_high;
    t_nibble r_check,  n_check;

    logic    r_out_valid;
    logic    r_kind,   n_kind;
    t_byte   r_data,   n_data;
    t_status r_status, n_status;
    logic    r_last,   n_last;
    logic    emit;

    logic    advance;
    t_hex    hex;
    t_count  chars;
    t_count  count_inc;

    assign advance   = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || advance;
    assign hex       = hex_decode(r_in_byte);
    assign chars     = {r_payload_bytes, 1'b0};
    assign count_inc = r_count + t_count'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_bytes <= RST_PAYLOAD_BYTES;
            r_start_code    <= RST_START_CODE;
            r_nak_code      <= RST_NAK_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAYLOAD_BYTES: r_payload_bytes <= i_cfg_data;
                CFG_START_CODE:    r_start_code    <= i_cfg_data;
                CFG_NAK_CODE:      r_nak_code      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_DATA: begin
                if (hex.bad) begin
                    n_phase = PH_HUNT;
                end else if (count_inc >= chars) begin
                    n_phase = PH_ETX;
                end
            end
            PH_ETX:  n_phase = PH_CKHI;
            PH_CKHI: n_phase = hex.bad ? PH_HUNT : PH_CKLO;
            PH_CKLO: n_phase = PH_HUNT;
            default: begin
                n_phase = PH_HUNT;
                if (r_in_byte == r_start_code) begin
                    n_phase = (chars == '0) ? PH_ETX : PH_DATA;
                end
            end
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_sum    = r_sum;
        n_high   = r_high;
        n_check  = r_check;
        emit     = 1'b0;
        n_kind   = 1'b0;
        n_data   = '0;
        n_status = ST_OK;
        n_last   = 1'b0;
        case (r_phase)
            PH_DATA: begin
                if (hex.bad) begin
                    emit     = 1'b1;
                    n_kind   = 1'b1;
                    n_status = ST_BADCHAR;
                    n_last   = 1'b1;
                end else begin
                    n_sum   = r_sum + r_in_byte;
                    n_count = count_inc;
                    if (count_inc[0]) begin
                        n_high = hex.value;
                    end else begin
                        emit   = 1'b1;
                        n_data = {r_high, hex.value};
                    end
                end
            end
            PH_ETX: begin
                n_sum = r_sum + r_in_byte;
            end
            PH_CKHI: begin
                if (hex.bad) begin
                    emit     = 1'b1;
                    n_kind   = 1'b1;
                    n_status = ST_BADCHAR;
                    n_last   = 1'b1;
                end else begin
                    n_check = hex.value;
                end
            end
            PH_CKLO: begin
                emit   = 1'b1;
                n_kind = 1'b1;
                n_last = 1'b1;
                if (hex.bad) begin
                    n_status = ST_BADCHAR;
                end else if ({r_check, hex.value} == r_sum) begin
                    n_status = ST_OK;
                end else begin
                    n_status = ST_MISMATCH;
                end
            end
            default: begin
                if (r_in_byte == r_start_code) begin
                    n_count = '0;
                    n_sum   = '0;
                    n_high  = '0;
                    n_check = '0;
                end else if (r_in_byte == r_nak_code) begin
                    emit     = 1'b1;
                    n_kind   = 1'b1;
                    n_status = ST_NAK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_sum   <= '0;
            r_high  <= '0;
            r_check <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_high  <= n_high;
            r_check <= n_check;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_kind   <= n_kind;
            r_data   <= n_data;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_data_byte   = r_data;
    assign o_status      = r_status;
    assign o_last        = r_last;

    a_data_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_kind |-> r_status == ST_OK && !r_last)
        else $error("data result carries status or last");

    a_nak_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_NAK |-> r_kind && !r_last)
        else $error("NAK status marked as frame end");

    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit && n_last |=> r_phase == PH_HUNT)
        else $error("frame closed without returning to hunting");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_res_ready |=> r_out_valid)
        else $error("stalled result dropped");

endmodule
